### rtl/pretrade_risk_check_defines.svh
// ----------------------------------------------------------------------------
// Pre-trade risk check: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PRETRADE_RISK_CHECK_DEFINES_SVH
`define PRETRADE_RISK_CHECK_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent
`define PRT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent
`define PRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/prt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pre-trade risk check package
// Sizes, register indexes, verdict codes, state type and control bundles.
// ----------------------------------------------------------------------------
package prt_pkg;

  // Structure sizes
  localparam int DUP_DEPTH  = 64;
  localparam int NUM_VENUES = 16;
  localparam int SCALE      = 100000000;

  // Field widths
  localparam int ID_W       = 64;
  localparam int PRICE_W    = 64;
  localparam int QTY_W      = 63;
  localparam int LIMIT_W    = 63;
  localparam int COUNT_W    = 32;
  localparam int SEC_W      = 32;
  localparam int VENUE_W    = 8;
  localparam int VERDICT_W  = 2;
  localparam int TOTAL_W    = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  // Derived sizes
  localparam int VIDX_W  = (NUM_VENUES > 1) ? $clog2(NUM_VENUES) : 1;
  localparam int SUM_W   = (COUNT_W + VIDX_W > TOTAL_W) ? COUNT_W + VIDX_W : TOTAL_W;
  localparam int SCALE_W = $clog2(SCALE + 1);
  localparam int LO_W    = 32;
  localparam int HI_W    = QTY_W - LO_W;
  localparam int PROD_W  = 2 * QTY_W;
  localparam int LIMP_W  = LIMIT_W + SCALE_W;

  localparam logic [SCALE_W-1:0] SCALE_C      = SCALE_W'(SCALE);
  localparam logic [VENUE_W:0]   NUM_VENUES_C = (VENUE_W + 1)'(NUM_VENUES);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRADING_ENABLE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ORDER_VALUE     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_NOTIONAL        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OPEN_PER_VENUE  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE_PER_SECOND = CFG_IDX_W'(4);

  // Request codes
  localparam logic REQ_NEW   = 1'b0;
  localparam logic REQ_CLOSE = 1'b1;

  // Verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_OK   = VERDICT_W'(0);
  localparam logic [VERDICT_W-1:0] VERDICT_RISK = VERDICT_W'(1);
  localparam logic [VERDICT_W-1:0] VERDICT_DUP  = VERDICT_W'(2);
  localparam logic [VERDICT_W-1:0] VERDICT_RATE = VERDICT_W'(3);

  typedef logic [ID_W-1:0] id_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DECIDE
  } state_t;

  // Duplicate chain controls
  typedef struct packed {
    logic lookup;
    logic reduce;
    logic push;
  } dup_ctl_t;

  // Size unit stage enables
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
  } size_ctl_t;

endpackage

### rtl/prt_dup_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate chain cell
// Holds one recently accepted id, compares it with the lookup id and hands
// its entry to the next cell on a push.
// ----------------------------------------------------------------------------
module prt_dup_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  prt_pkg::dup_ctl_t ctl,
  input  prt_pkg::id_t      query_id,
  input  prt_pkg::id_t      prev_id,
  input  logic              prev_vld,
  output prt_pkg::id_t      id_o,
  output logic              vld_o,
  output logic              hit_o
);

  prt_pkg::id_t id_r;
  logic         vld_r;
  logic         hit_r;

  // Shift valid bit and latch compare result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      if (ctl.push) begin
        vld_r <= prev_vld;
      end
      if (ctl.lookup) begin
        hit_r <= vld_r && (id_r == query_id);
      end
    end
  end

  // Shift id payload
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      id_r <= prev_id;
    end
  end

  assign id_o  = id_r;
  assign vld_o = vld_r;
  assign hit_o = hit_r;

endmodule

### rtl/prt_dup_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Duplicate id chain
// Row of cells holding the most recently accepted ids, newest at the head.
// A push shifts every entry one cell down; the oldest falls off the end.
// ----------------------------------------------------------------------------
module prt_dup_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  prt_pkg::dup_ctl_t ctl,
  input  prt_pkg::id_t      query_id,
  input  prt_pkg::id_t      push_id,
  output logic              dup_o
);

  prt_pkg::id_t                   cell_id  [prt_pkg::DUP_DEPTH];
  logic                           cell_vld [prt_pkg::DUP_DEPTH];
  logic [prt_pkg::DUP_DEPTH-1:0]  hit;
  logic                           dup_r;

  // Build the row; the head takes the new id
  for (genvar i = 0; i < prt_pkg::DUP_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      prt_dup_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .query_id (query_id),
        .prev_id  (push_id),
        .prev_vld (1'b1),
        .id_o     (cell_id[i]),
        .vld_o    (cell_vld[i]),
        .hit_o    (hit[i])
      );
    end else begin : g_body
      prt_dup_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .query_id (query_id),
        .prev_id  (cell_id[i-1]),
        .prev_vld (cell_vld[i-1]),
        .id_o     (cell_id[i]),
        .vld_o    (cell_vld[i]),
        .hit_o    (hit[i])
      );
    end
  end

  // Merge registered per-cell hits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dup_r <= 1'b0;
    end else if (ctl.reduce) begin
      dup_r <= |hit;
    end
  end

  assign dup_o = dup_r;

endmodule

### rtl/prt_size_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order size unit
// Forms price*quantity from partial products of 32-bit and 31-bit halves
// and the tighter limit times SCALE, then flags an order above the limit.
// ----------------------------------------------------------------------------
module prt_size_unit (
  input  logic                         clk,
  input  prt_pkg::size_ctl_t           ctl,
  input  logic [prt_pkg::QTY_W-1:0]    price_mag,
  input  logic [prt_pkg::QTY_W-1:0]    quantity,
  input  logic [prt_pkg::LIMIT_W-1:0]  max_order_value,
  input  logic [prt_pkg::LIMIT_W-1:0]  notional_cap,
  output logic                         over_o
);

  localparam int LO_W    = prt_pkg::LO_W;
  localparam int HI_W    = prt_pkg::HI_W;
  localparam int SCALE_W = prt_pkg::SCALE_W;

  logic [prt_pkg::LIMIT_W-1:0]  lim_r;
  logic [2*LO_W-1:0]            ll_r;
  logic [LO_W+HI_W-1:0]         lh_r;
  logic [LO_W+HI_W-1:0]         hl_r;
  logic [2*HI_W-1:0]            hh_r;
  logic [LO_W+HI_W:0]           mid_r;
  logic [LO_W+SCALE_W-1:0]      llim_lo_r;
  logic [HI_W+SCALE_W-1:0]      llim_hi_r;
  logic [prt_pkg::PROD_W-1:0]   prod_r;
  logic [prt_pkg::LIMP_W-1:0]   limp_r;

  always_ff @(posedge clk) begin
    // Track the tighter of the two limits
    lim_r <= (max_order_value < notional_cap) ? max_order_value : notional_cap;

    // Partial products of the order size
    if (ctl.load) begin
      ll_r <= price_mag[LO_W-1:0]           * quantity[LO_W-1:0];
      lh_r <= price_mag[LO_W-1:0]           * quantity[prt_pkg::QTY_W-1:LO_W];
      hl_r <= price_mag[prt_pkg::QTY_W-1:LO_W] * quantity[LO_W-1:0];
      hh_r <= price_mag[prt_pkg::QTY_W-1:LO_W] * quantity[prt_pkg::QTY_W-1:LO_W];
    end

    // Cross terms and limit partial products
    if (ctl.mul) begin
      mid_r     <= {1'b0, lh_r} + {1'b0, hl_r};
      llim_lo_r <= lim_r[LO_W-1:0] * prt_pkg::SCALE_C;
      llim_hi_r <= lim_r[prt_pkg::LIMIT_W-1:LO_W] * prt_pkg::SCALE_C;
    end

    // Final sums
    if (ctl.sum) begin
      prod_r <= {hh_r, ll_r} + prt_pkg::PROD_W'({mid_r, {LO_W{1'b0}}});
      limp_r <= prt_pkg::LIMP_W'(llim_lo_r) + {llim_hi_r, {LO_W{1'b0}}};
    end
  end

  assign over_o = prod_r > prt_pkg::PROD_W'(limp_r);

endmodule

### rtl/pretrade_risk_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pre-trade risk check
// Screens new orders and tracks open orders per venue.
// ----------------------------------------------------------------------------
// One request is in work at a time. Its transfer edge loads the partial
// products of price*quantity, split into a 32-bit low and 31-bit high half,
// and looks the id up in every duplicate cell at once; in ST_MUL the block
// forms the cross term and the limit*SCALE partial products, in ST_SUM it
// sums them in the size unit, and in ST_DECIDE it makes the verdict and
// updates the state. A new request is taken only after the last one leaves
// ST_DECIDE. The result then waits in the output register, and the next
// request can be taken on the following edge; a held result stops only the
// decision step. The recent ids live in a 64-cell shift chain, newest first.
// Reset needs no clearing pass. Configuration writes are taken at any edge
// but are meant for idle periods only.
// ----------------------------------------------------------------------------
module pretrade_risk_check (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             cfg_we,
  input  logic [prt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prt_pkg::CFG_DATA_W-1:0]   cfg_wdata,

  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [prt_pkg::VENUE_W-1:0]      in_venue,
  input  logic signed [prt_pkg::PRICE_W-1:0] in_price,
  input  logic [prt_pkg::QTY_W-1:0]        in_quantity,
  input  logic [prt_pkg::ID_W-1:0]         in_order_ident,
  input  logic [prt_pkg::SEC_W-1:0]        in_now_second,

  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [prt_pkg::VERDICT_W-1:0]    out_verdict,
  output logic [prt_pkg::TOTAL_W-1:0]      out_total_open
);

  localparam int VIDX_W  = prt_pkg::VIDX_W;
  localparam int COUNT_W = prt_pkg::COUNT_W;
  localparam int SUM_W   = prt_pkg::SUM_W;

  prt_pkg::state_t state_r, state_nxt;

  // Configuration registers
  logic                        en_r;
  logic [prt_pkg::LIMIT_W-1:0] max_order_r;
  logic [prt_pkg::LIMIT_W-1:0] notional_cap_r;
  logic [COUNT_W-1:0]          max_open_r;
  logic [COUNT_W-1:0]          max_rate_r;

  // Request in work
  logic                        req_r;
  logic [VIDX_W-1:0]           vidx_r;
  logic [prt_pkg::SEC_W-1:0]   now_r;
  prt_pkg::id_t                id_r;
  logic                        market_r;
  logic [COUNT_W-1:0]          cnt_r;

  // Tracking state
  logic [COUNT_W-1:0]          venue_cnt_r [prt_pkg::NUM_VENUES];
  logic [SUM_W-1:0]            sum_r;
  logic [prt_pkg::SEC_W-1:0]   win_start_r;
  logic [COUNT_W-1:0]          win_orders_r;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [prt_pkg::VERDICT_W-1:0] out_verdict_r;
  logic [prt_pkg::TOTAL_W-1:0]   out_total_r;

  // Handshake and control
  logic                accept;
  logic                fire;
  prt_pkg::dup_ctl_t   dup_ctl;
  prt_pkg::size_ctl_t  size_ctl;
  logic                dup;
  logic                over;

  // Decision
  logic [VIDX_W-1:0]             vidx;
  logic                          market;
  logic [COUNT_W-1:0]            wo_eff;
  logic [prt_pkg::VERDICT_W-1:0] verdict;
  logic                          ord_acc;
  logic                          win_upd;
  logic [COUNT_W-1:0]            cnt_new;
  logic [SUM_W-1:0]              sum_new;
  logic [prt_pkg::TOTAL_W-1:0]   total_new;

  // Map out-of-range venues to venue 0
  assign vidx   = ({1'b0, in_venue} < prt_pkg::NUM_VENUES_C) ? in_venue[VIDX_W-1:0] : '0;
  assign market = (in_price[prt_pkg::PRICE_W-1] || (in_price == '0)) && (in_quantity != '0);

  prt_dup_chain u_dup_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (dup_ctl),
    .query_id (in_order_ident),
    .push_id  (id_r),
    .dup_o    (dup)
  );

  prt_size_unit u_size_unit (
    .clk             (clk),
    .ctl             (size_ctl),
    .price_mag       (in_price[prt_pkg::QTY_W-1:0]),
    .quantity        (in_quantity),
    .max_order_value (max_order_r),
    .notional_cap    (notional_cap_r),
    .over_o          (over)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = prt_pkg::ST_MUL;
        end
      end
      prt_pkg::ST_MUL:    state_nxt = prt_pkg::ST_SUM;
      prt_pkg::ST_SUM:    state_nxt = prt_pkg::ST_DECIDE;
      prt_pkg::ST_DECIDE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = prt_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = prt_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall      = 1'b1;
    accept        = 1'b0;
    fire          = 1'b0;
    size_ctl.load = 1'b0;
    size_ctl.mul  = 1'b0;
    size_ctl.sum  = 1'b0;
    dup_ctl.reduce = 1'b0;
    case (state_r)
      prt_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        accept        = in_valid;
        size_ctl.load = in_valid;
      end
      prt_pkg::ST_MUL: begin
        size_ctl.mul   = 1'b1;
        dup_ctl.reduce = 1'b1;
      end
      prt_pkg::ST_SUM: begin
        size_ctl.sum = 1'b1;
      end
      prt_pkg::ST_DECIDE: begin
        fire = !out_valid_r || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    dup_ctl.lookup = accept;
    dup_ctl.push   = fire && ord_acc;
  end

  // Checks in priority order, then count updates
  always_comb begin
    wo_eff  = (win_start_r != now_r) ? '0 : win_orders_r;
    verdict = prt_pkg::VERDICT_OK;
    ord_acc = 1'b0;
    win_upd = 1'b0;
    if (req_r == prt_pkg::REQ_NEW) begin
      if (!en_r) begin
        verdict = prt_pkg::VERDICT_RISK;
      end else if (dup) begin
        verdict = prt_pkg::VERDICT_DUP;
      end else if (cnt_r >= max_open_r) begin
        verdict = prt_pkg::VERDICT_RISK;
      end else begin
        win_upd = 1'b1;
        if (wo_eff >= max_rate_r) begin
          verdict = prt_pkg::VERDICT_RATE;
        end else if (!market_r && over) begin
          verdict = prt_pkg::VERDICT_RISK;
        end else begin
          ord_acc = 1'b1;
        end
      end
    end

    cnt_new = cnt_r;
    sum_new = sum_r;
    if (req_r == prt_pkg::REQ_NEW) begin
      if (ord_acc && (cnt_r != prt_pkg::COUNT_MAX)) begin
        cnt_new = cnt_r + COUNT_W'(1);
        sum_new = sum_r + SUM_W'(1);
      end
    end else if (cnt_r != '0) begin
      cnt_new = cnt_r - COUNT_W'(1);
      sum_new = sum_r - SUM_W'(1);
    end
    total_new = (sum_new > SUM_W'(prt_pkg::TOTAL_MAX)) ? prt_pkg::TOTAL_MAX
                                                        : sum_new[prt_pkg::TOTAL_W-1:0];
  end

  // Hold result until the transfer completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= prt_pkg::ST_IDLE;
      en_r           <= 1'b0;
      max_order_r    <= '0;
      notional_cap_r <= '0;
      max_open_r     <= '0;
      max_rate_r     <= '0;
      sum_r          <= '0;
      win_start_r    <= '0;
      win_orders_r   <= '0;
      out_valid_r    <= 1'b0;
      for (int i = 0; i < prt_pkg::NUM_VENUES; i++) begin
        venue_cnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Register writes
      if (cfg_we) begin
        case (cfg_index)
          prt_pkg::REG_TRADING_ENABLE:      en_r           <= cfg_wdata[0];
          prt_pkg::REG_MAX_ORDER_VALUE:     max_order_r    <= cfg_wdata;
          prt_pkg::REG_MAX_NOTIONAL:        notional_cap_r <= cfg_wdata;
          prt_pkg::REG_MAX_OPEN_PER_VENUE:  max_open_r     <= cfg_wdata[COUNT_W-1:0];
          prt_pkg::REG_MAX_RATE_PER_SECOND: max_rate_r     <= cfg_wdata[COUNT_W-1:0];
          default: begin
          end
        endcase
      end

      // Commit the decision
      if (fire) begin
        venue_cnt_r[vidx_r] <= cnt_new;
        sum_r               <= sum_new;
        if (win_upd) begin
          win_start_r  <= now_r;
          win_orders_r <= ord_acc ? wo_eff + COUNT_W'(1) : wo_eff;
        end
      end
    end
  end

  // Capture the request on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req_type;
      vidx_r   <= vidx;
      now_r    <= in_now_second;
      id_r     <= in_order_ident;
      market_r <= market;
      cnt_r    <= venue_cnt_r[vidx];
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      out_verdict_r <= verdict;
      out_total_r   <= total_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_total_open = out_total_r;

endmodule

### rtl/prt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pre-trade risk check port checker
// Watches the top-level channels for sequencing and hold behavior.
// ----------------------------------------------------------------------------
`include "pretrade_risk_check_defines.svh"

module prt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [prt_pkg::VERDICT_W-1:0]    out_verdict,
  input logic [prt_pkg::TOTAL_W-1:0]      out_total_open
);

  // One request in work: input closes right after a transfer
  `PRT_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall, "input open after transfer")

  // No result can appear in the cycle after a transfer
  `PRT_ASSERT_NEXT(a_no_early_out, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result too early")

  // A fresh result means the block is free for the next request
  `PRT_ASSERT_SAME(a_free_on_out, clk, rst_n, $rose(out_valid), !in_stall, "busy with result shown")

  // Held result keeps its payload
  `PRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_verdict) && $stable(out_total_open), "held result changed")

endmodule

bind pretrade_risk_check prt_checker u_prt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_verdict    (out_verdict),
  .out_total_open (out_total_open)
);
